>>> design/tibf_pkg.sv
`timescale 1ns / 1ps

package tibf_pkg;

  localparam logic [7:0] IacByte     = 8'd255;
  localparam logic [7:0] CmdWill     = 8'd251;
  localparam logic [7:0] CmdDont     = 8'd254;
  localparam logic [7:0] CrByte      = 8'd13;
  localparam logic [7:0] LfByte      = 8'd10;
  localparam logic [7:0] NulByte     = 8'd0;
  localparam logic [7:0] NoFlushByte = 8'd4;

  // Result buffer depth and its index/count widths.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_COMMAND = 2'd1,
    MODE_OPTION  = 2'd2,
    MODE_AFTERCR = 2'd3
  } tibf_mode_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       immediate;
    logic       flush;
    logic       last;
  } tibf_res_t;

  // Zero, one or two results produced by one input byte.
  typedef struct packed {
    logic [1:0] cnt;
    tibf_res_t  res0;
    tibf_res_t  res1;
  } tibf_push_t;

  function automatic tibf_res_t tibf_plain(input logic [7:0] b);
    tibf_res_t r;
    r.out_byte  = b;
    r.immediate = (b != LfByte) && (b != CrByte);
    r.flush     = (b != NoFlushByte);
    r.last      = 1'b1;
    return r;
  endfunction

endpackage

>>> design/tibf_in_if.sv
`timescale 1ns / 1ps

interface tibf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

>>> design/tibf_out_if.sv
`timescale 1ns / 1ps

interface tibf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       immediate;
  logic       flush;
  logic       last;

  modport source (output valid, output out_byte, output immediate, output flush,
                  output last, input ready);
  modport sink (input valid, input out_byte, input immediate, input flush,
                input last, output ready);
endinterface

>>> design/tibf_decode.sv
`timescale 1ns / 1ps

module tibf_decode import tibf_pkg::*; (
  input  tibf_mode_e mode_i,
  input  logic [7:0] byte_i,
  output tibf_mode_e mode_o,
  output tibf_push_t push_o
);

  always_comb begin
    mode_o = mode_i;
    push_o = '0;
    unique case (mode_i)
      MODE_NORMAL: begin
        if (byte_i == IacByte) begin
          mode_o = MODE_COMMAND;
        end else if (byte_i == CrByte) begin
          mode_o = MODE_AFTERCR;
        end else begin
          push_o.cnt  = 2'd1;
          push_o.res0 = tibf_plain(byte_i);
        end
      end
      MODE_COMMAND: begin
        if (byte_i >= CmdWill && byte_i <= CmdDont) begin
          mode_o = MODE_OPTION;
        end else begin
          mode_o = MODE_NORMAL;
          // escaped IAC passes one literal 255, no flush
          if (byte_i == IacByte) begin
            push_o.cnt  = 2'd1;
            push_o.res0 = '{out_byte: IacByte, immediate: 1'b1, flush: 1'b0,
                            last: 1'b1};
          end
        end
      end
      MODE_OPTION: begin
        mode_o = MODE_NORMAL;
      end
      MODE_AFTERCR: begin
        if (byte_i == LfByte || byte_i == NulByte) begin
          mode_o      = MODE_NORMAL;
          push_o.cnt  = 2'd1;
          push_o.res0 = '{out_byte: CrByte, immediate: 1'b0, flush: 1'b1,
                          last: 1'b1};
        end else if (byte_i == IacByte) begin
          mode_o      = MODE_COMMAND;
          push_o.cnt  = 2'd1;
          push_o.res0 = '{out_byte: CrByte, immediate: 1'b0, flush: 1'b0,
                          last: 1'b1};
        end else begin
          mode_o      = MODE_NORMAL;
          push_o.cnt  = 2'd2;
          push_o.res0 = '{out_byte: CrByte, immediate: 1'b0, flush: 1'b0,
                          last: 1'b0};
          push_o.res1 = tibf_plain(byte_i);
        end
      end
    endcase
  end

endmodule

>>> design/tibf_res_fifo.sv
`timescale 1ns / 1ps

module tibf_res_fifo import tibf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tibf_push_t push_i,
  output logic       space_o,
  tibf_out_if.source res_o
);

  tibf_res_t           mem_q [FifoDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                pop;
  logic [PtrW-1:0]     wr_ptr_nxt;

  assign pop        = res_o.valid && res_o.ready;
  assign wr_ptr_nxt = wr_ptr_q + PtrW'(1);
  // room for the worst case of two results
  assign space_o    = (cnt_q <= CntW'(FifoDepth - 2));

  assign res_o.valid     = (cnt_q != '0);
  assign res_o.out_byte  = mem_q[rd_ptr_q].out_byte;
  assign res_o.immediate = mem_q[rd_ptr_q].immediate;
  assign res_o.flush     = mem_q[rd_ptr_q].flush;
  assign res_o.last      = mem_q[rd_ptr_q].last;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.cnt);
    rd_ptr_d = pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.res1;
    end
  end

endmodule

>>> design/telnet_input_byte_filter_core.sv
`timescale 1ns / 1ps

// Telnet input filter: cleans a received telnet byte stream for a command
// shell. IAC sequences are removed (WILL/WONT/DO/DONT also drop their option
// byte), IAC IAC yields a literal 255 with immediate set and no flush, and a
// CR is held back until the next byte shows whether it ends a line (CR LF or
// CR NUL give one flushing CR). Each result carries immediate (not CR/LF),
// flush (not 4) and last (final result of its input byte). Filter state
// persists across packets and resets to normal mode. Timing: a request
// enters an input register, is decoded combinationally and its zero, one
// or two results are written to a four-entry result buffer, so a new
// request can be taken every cycle while the buffer has two free entries.
// The result port drains one result per cycle while the consumer is ready,
// so a byte that releases a held CR along with itself leaves two results
// for the port to drain instead of one.

module telnet_input_byte_filter_core import tibf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tibf_in_if.sink    req_i,
  tibf_out_if.source res_o
);

  logic       req_valid_q, req_valid_d;
  logic [7:0] req_byte_q;
  tibf_mode_e mode_q, mode_d, mode_dec;
  tibf_push_t push_dec, push;
  logic       space;
  logic       process;

  // Decode the held request only when the buffer can take two results.
  assign process     = req_valid_q && space;
  assign req_i.ready = !req_valid_q || space;

  tibf_decode u_decode (
    .mode_i (mode_q),
    .byte_i (req_byte_q),
    .mode_o (mode_dec),
    .push_o (push_dec)
  );

  always_comb begin
    push        = push_dec;
    mode_d      = mode_q;
    req_valid_d = req_valid_q;
    if (!process) begin
      push.cnt = 2'd0;
    end else begin
      mode_d = mode_dec;
    end
    // advance the input register whenever it is free or being drained
    if (req_i.ready) begin
      req_valid_d = req_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      mode_q      <= MODE_NORMAL;
    end else begin
      req_valid_q <= req_valid_d;
      mode_q      <= mode_d;
    end
  end

  // hold the payload until the request is decoded
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_byte_q <= req_i.in_byte;
    end
  end

  tibf_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .res_o   (res_o)
  );

endmodule
